>>> rtl/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and constants for the CAN acceptance filter table: operation
// codes, sequencer states and the packed layout of one stored filter.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned CNT_OW = 5;   // width of the reported entry count

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_SHIFT_READ,
    ST_SHIFT_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] mask;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

>>> rtl/caf_table.sv
// ----------------------------------------------------------------------------
// caf_table
// Filter storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module caf_table #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  caf_pkg::entry_t    wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output caf_pkg::entry_t    rdata
);
  import caf_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/caf_cmp.sv
// ----------------------------------------------------------------------------
// caf_cmp
// Shared compare unit: masked match for check, exact ID match for remove.
// ----------------------------------------------------------------------------
module caf_cmp (
  input  logic [caf_pkg::ID_W-1:0] key,
  input  caf_pkg::entry_t          entry,
  input  logic                     exact,
  output logic                     hit
);
  import caf_pkg::*;

  logic [ID_W-1:0] eff_mask;

  // an exact compare is a masked compare with every bit enabled
  assign eff_mask = exact ? {ID_W{1'b1}} : entry.mask;
  assign hit      = ((key & eff_mask) == (entry.id & eff_mask));

endmodule

>>> rtl/can_acceptance_filter_table_top.sv
// ----------------------------------------------------------------------------
// can_acceptance_filter_table_top
// Table of ID/mask receive acceptance filters with check, add, remove and
// clear requests, walked one slot at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the operation code,
//   s_tdata the frame ID and (for add) the new mask. Each request gives
//   exactly one result transfer on the m_ stream: the ok flag and the number
//   of filters held after the operation.
//   Add and clear go straight to the final state and load their result from
//   there as soon as the output register is free. Check and remove
//   walk the packed table through a single-port read and one shared compare
//   unit, visiting each slot in turn (issue the read, then test the
//   registered data); a remove then moves each later filter down one slot,
//   reading it and then writing it back one slot lower.
//   s_tready is high only while the sequencer is idle, one request at a time.
//   A finished result sits in the output register; the next request is taken
//   while it waits. If the receiver stalls, the following request finishes
//   its walk and holds in its final state until the output register frees.
//   Reset empties the table (count zero) and drops any pending result; the
//   filter storage itself is not cleared, only slots below the count are read.
// ----------------------------------------------------------------------------
module can_acceptance_filter_table_top #(
  parameter int unsigned FILTER_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [31:0] s_tdata,   // [15:0] frame_id, [31:16] id_mask
  input  logic [1:0] s_tuser,    // [1:0] func
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata     // [0] ok, [5:1] entry_count, [7:6] zero
);
  import caf_pkg::*;

  localparam int unsigned IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(FILTER_SLOTS + 1);
  localparam int unsigned EXT_W = CNT_W + CNT_OW;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [ID_W-1:0]  key, key_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             res_ok, res_ok_next;

  logic             out_ok;
  logic [CNT_OW-1:0] out_count;

  logic             s_xfer;
  logic             out_free;
  logic [CNT_W-1:0] ptr_inc;
  logic             table_full;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;
  logic             hit;
  logic [EXT_W-1:0] count_ext;

  assign s_tready   = (state == ST_IDLE);
  assign s_xfer     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign ptr_inc    = ptr + CNT_W'(1);
  assign table_full = (count == CNT_W'(FILTER_SLOTS));

  caf_table #(
    .DEPTH  (FILTER_SLOTS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  caf_cmp u_cmp (
    .key   (key),
    .entry (rdata),
    .exact (op == OP_REMOVE),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // request payload and walk pointer need no reset
  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    ptr    <= ptr_next;
    res_ok <= res_ok_next;
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    key_next    = key;
    count_next  = count;
    ptr_next    = ptr;
    res_ok_next = res_ok;
    we          = 1'b0;
    waddr       = ptr[IDX_W-1:0];
    wdata       = rdata;
    raddr       = ptr[IDX_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          op_next  = op_t'(s_tuser);
          key_next = s_tdata[15:0];
          ptr_next = '0;
          unique case (op_t'(s_tuser)) inside
            OP_CHECK, OP_REMOVE: begin
              state_next = ST_READ;
            end
            OP_ADD: begin
              // append at the end unless the table is full
              res_ok_next = !table_full;
              if (!table_full) begin
                we         = 1'b1;
                waddr      = count[IDX_W-1:0];
                wdata.id   = s_tdata[15:0];
                wdata.mask = s_tdata[31:16];
                count_next = count + CNT_W'(1);
              end
              state_next = ST_DONE;
            end
            OP_CLEAR: begin
              count_next  = '0;
              res_ok_next = 1'b1;
              state_next  = ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_READ: begin
        // walked past the last held slot: no match
        if (ptr < count) begin
          state_next = ST_TEST;
        end else begin
          res_ok_next = 1'b0;
          state_next  = ST_DONE;
        end
      end

      ST_TEST: begin
        if (hit) begin
          res_ok_next = 1'b1;
          state_next  = (op == OP_REMOVE) ? ST_SHIFT_READ : ST_DONE;
        end else begin
          ptr_next   = ptr_inc;
          state_next = ST_READ;
        end
      end

      ST_SHIFT_READ: begin
        // close the gap: fetch the next slot, or finish and drop the count
        raddr = ptr_inc[IDX_W-1:0];
        if (ptr_inc < count) begin
          state_next = ST_SHIFT_WRITE;
        end else begin
          count_next = count - CNT_W'(1);
          state_next = ST_DONE;
        end
      end

      ST_SHIFT_WRITE: begin
        we         = 1'b1;
        waddr      = ptr[IDX_W-1:0];
        wdata      = rdata;
        ptr_next   = ptr_inc;
        state_next = ST_SHIFT_READ;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // report the count masked to the output field width
  assign count_ext = {{CNT_OW{1'b0}}, count};

  // output register: load on leaving the final state, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_ok    <= res_ok;
      out_count <= count_ext[CNT_OW-1:0];
    end
  end

  assign m_tdata = {2'b00, out_count, out_ok};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FILTER_SLOTS))
    else $error("filter count exceeds table depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished result not presented");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST || state == ST_SHIFT_WRITE) |-> (ptr < count))
    else $error("walk pointer beyond held filters");
`endif

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CAN acceptance filter table. A short table of
// directed requests (empty table, extremes, a full table, duplicates, clear)
// runs first. Random check/add/remove/clear traffic shaped around the filters
// actually held follows. Every result transfer is compared against a local
// model of the filter table while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import caf_pkg::*;

  localparam int SLOTS          = 16;
  localparam int RAND_ITEMS     = 1130;
  localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 4 * SLOTS + 8;

  // Expected content of one result transfer
  typedef struct packed {
    logic              ok;
    logic [CNT_OW-1:0] count;
  } verdict_t;

  // One directed request; when known_result is set the expected result is
  // typed in the row, otherwise it comes from the table model
  typedef struct packed {
    op_t         op;
    logic [15:0] fid;
    logic [15:0] msk;
    logic        known_result;
    logic        ok;
    logic [4:0]  count;
  } directed_row_t;

  localparam int DIR_ROWS = 26;
  directed_row_t directed_rows [DIR_ROWS] = '{
    // empty table: check rejects, remove fails
    '{OP_CHECK,  16'h0000, 16'h0000, 1'b1, 1'b0, 5'd0},
    '{OP_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 5'd0},
    // extremes of id and mask
    '{OP_ADD,    16'h0000, 16'hFFFF, 1'b1, 1'b1, 5'd1},
    '{OP_ADD,    16'hFFFF, 16'h0000, 1'b1, 1'b1, 5'd2},
    // zero-mask filter accepts anything; the mask field is ignored by check
    '{OP_CHECK,  16'h5A5A, 16'hFFFF, 1'b0, 1'b0, 5'd0},
    '{OP_REMOVE, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 5'd1},
    // duplicate identifiers
    '{OP_ADD,    16'h0123, 16'h0FF0, 1'b1, 1'b1, 5'd2},
    '{OP_ADD,    16'h0123, 16'hFFFF, 1'b1, 1'b1, 5'd3},
    '{OP_REMOVE, 16'h7777, 16'h1234, 1'b0, 1'b0, 5'd0},
    // fill the table up to its last slot
    '{OP_ADD,    16'h8000, 16'h8000, 1'b1, 1'b1, 5'd4},
    '{OP_ADD,    16'h4001, 16'hF00F, 1'b1, 1'b1, 5'd5},
    '{OP_ADD,    16'h2002, 16'h07FF, 1'b1, 1'b1, 5'd6},
    '{OP_ADD,    16'h1004, 16'hFF00, 1'b1, 1'b1, 5'd7},
    '{OP_ADD,    16'h0808, 16'h00FF, 1'b1, 1'b1, 5'd8},
    '{OP_ADD,    16'h0410, 16'hAAAA, 1'b1, 1'b1, 5'd9},
    '{OP_ADD,    16'h0220, 16'h5555, 1'b1, 1'b1, 5'd10},
    '{OP_ADD,    16'h0140, 16'h0001, 1'b1, 1'b1, 5'd11},
    '{OP_ADD,    16'h00FF, 16'hFFFE, 1'b1, 1'b1, 5'd12},
    '{OP_ADD,    16'hFF00, 16'h3C3C, 1'b1, 1'b1, 5'd13},
    '{OP_ADD,    16'hAAAA, 16'hC3C3, 1'b1, 1'b1, 5'd14},
    '{OP_ADD,    16'h5555, 16'h8001, 1'b1, 1'b1, 5'd15},
    '{OP_ADD,    16'h0123, 16'h0F0F, 1'b1, 1'b1, 5'd16},
    // full table refuses the add and keeps its count
    '{OP_ADD,    16'h1234, 16'hFFFF, 1'b1, 1'b0, 5'd16},
    // remove takes only the lowest duplicate
    '{OP_REMOVE, 16'h0123, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{OP_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 5'd0},
    '{OP_CHECK,  16'h0123, 16'h0000, 1'b1, 1'b0, 5'd0}
  };

  // DUT signals; every input holds a known value from time zero
  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [15:0] frame_id, [31:16] id_mask
  logic [1:0]  s_tuser  = OP_CHECK;  // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [0] ok, [5:1] entry_count, [7:6] zero

  can_acceptance_filter_table_top #(.FILTER_SLOTS(SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Model of the filter table, updated at each accepted request
  logic [15:0] tbl_id   [SLOTS];
  logic [15:0] tbl_mask [SLOTS];
  int          tbl_count;

  verdict_t pending_verdicts[$];

  // Flow control between the sender and the receiver process
  bit calm;                 // suppress random idling on both sides
  logic hold_req = 1'b0;    // ask the receiver for its long hold-off

  int mismatches;
  int results_seen;
  int n_check, n_check_hit, n_add, n_add_refused, n_remove, n_remove_hit;
  int n_clear, n_full;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the table model and return the result it must give
  function automatic verdict_t filter_table_apply(op_t op, logic [15:0] fid,
                                                  logic [15:0] msk);
    verdict_t v;
    int       i;
    int       hit;
    v.ok = 1'b0;
    hit  = -1;
    case (op)
      OP_CHECK: begin
        for (i = 0; i < tbl_count; i++)
          if (((fid ^ tbl_id[i]) & tbl_mask[i]) == 16'h0000) v.ok = 1'b1;
      end
      OP_ADD: begin
        if (tbl_count < SLOTS) begin
          tbl_id[tbl_count]   = fid;
          tbl_mask[tbl_count] = msk;
          tbl_count++;
          v.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < tbl_count && hit < 0; i++)
          if (tbl_id[i] == fid) hit = i;
        if (hit >= 0) begin
          // close the gap left by the removed filter
          for (i = hit; i + 1 < tbl_count; i++) begin
            tbl_id[i]   = tbl_id[i + 1];
            tbl_mask[i] = tbl_mask[i + 1];
          end
          tbl_count--;
          v.ok = 1'b1;
        end
      end
      default: begin
        tbl_count = 0;
        v.ok      = 1'b1;
      end
    endcase
    v.count = tbl_count[CNT_OW-1:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Offer one request, hold it until the transfer, then queue its result
  task automatic issue(op_t op, logic [15:0] fid, logic [15:0] msk,
                       logic known_result, logic k_ok, logic [4:0] k_count);
    verdict_t v;
    if (!calm && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {msk, fid};
    do @(posedge clk); while (!s_tready);
    v = filter_table_apply(op, fid, msk);
    case (op)
      OP_CHECK:  begin n_check++;  n_check_hit   += v.ok; end
      OP_ADD:    begin
        n_add++;
        n_add_refused += !v.ok;
        n_full        += (v.ok && v.count == SLOTS);
      end
      OP_REMOVE: begin n_remove++; n_remove_hit  += v.ok; end
      default:   n_clear++;
    endcase
    if (known_result) begin
      v.ok    = k_ok;
      v.count = k_count;
    end
    pending_verdicts.push_back(v);
  endtask

  // Pick a random mask: mostly arbitrary, with full, single-bit, single-zero-bit,
  // 16'h07FF and all-zero masks mixed in
  function automatic logic [15:0] random_mask();
    int r;
    r = $urandom_range(0, 39);
    if (r < 6)  return 16'hFFFF;
    if (r < 10) return 16'h0001 << $urandom_range(0, 15);
    if (r < 13) return ~(16'h0001 << $urandom_range(0, 15));
    if (r == 13) return 16'h0000;
    if (r < 17) return 16'h07FF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Build a random request around the filters currently held, so that
  // checks hit and miss and removes find their target most of the time
  task automatic pick_request(output op_t op, output logic [15:0] fid,
                              output logic [15:0] msk);
    int r;
    int add_share;
    int k;
    r         = $urandom_range(0, 99);
    add_share = (tbl_count < 8) ? 45 : (tbl_count < SLOTS) ? 30 : 12;
    fid       = 16'($urandom_range(0, 65535));
    msk       = 16'($urandom_range(0, 65535));   // ignored except by add
    k         = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    if (r < 2) begin
      op = OP_CLEAR;
    end else if (r < 2 + add_share) begin
      op  = OP_ADD;
      msk = random_mask();
      // duplicate an identifier already held now and then
      if (tbl_count > 0 && $urandom_range(0, 4) == 0) fid = tbl_id[k];
    end else if ($urandom_range(0, 99) < 65) begin
      op = OP_CHECK;
      if (tbl_count > 0 && $urandom_range(0, 99) < 60) begin
        fid = (tbl_id[k] & tbl_mask[k]) | (fid & ~tbl_mask[k]);
        // flip one bit to probe the edge of the match
        if ($urandom_range(0, 99) < 20) fid[$urandom_range(0, 15)] ^= 1'b1;
      end
    end else begin
      op = OP_REMOVE;
      if (tbl_count > 0 && $urandom_range(0, 99) < 65) fid = tbl_id[k];
    end
  endtask

  // Receiver: check every result transfer, then pick next cycle's tready
  always @(posedge clk) begin
    verdict_t exp_v;
    int       hold_left;
    bit       hold_done;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", m_tdata, 0);
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (m_tdata[0] !== exp_v.ok)
            report_mismatch("ok", m_tdata[0], exp_v.ok);
          if (m_tdata[5:1] !== exp_v.count)
            report_mismatch("entry_count", m_tdata[5:1], exp_v.count);
          if (m_tdata[7:6] !== 2'b00)
            report_mismatch("tdata pad", m_tdata[7:6], 0);
        end
        results_seen++;
      end
      // long hold-off lets the block fill up and stall its input
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Watchdog: end the run once nothing has transferred for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("can_acceptance_filter_table_top verification failed");
    $finish;
  end

  // Sender: reset, directed table, random traffic, drain, verdict
  initial begin
    op_t         op;
    logic [15:0] fid;
    logic [15:0] msk;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int n = 0; n < DIR_ROWS; n++)
      issue(directed_rows[n].op, directed_rows[n].fid, directed_rows[n].msk,
            directed_rows[n].known_result, directed_rows[n].ok,
            directed_rows[n].count);

    // random part
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 450 && n < 650);
      if (n == 300) hold_req <= 1'b1;
      if (n == 800) begin
        // pause until the block has delivered everything
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
      end
      pick_request(op, fid, msk);
      issue(op, fid, msk, 1'b0, 1'b0, 5'd0);
    end
    s_tvalid <= 1'b0;

    // drain, then let the sequencer settle
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch("results still pending", pending_verdicts.size(), 0);

    $display("Run covered %0d checks (%0d accepted), %0d adds (%0d refused full), %0d clears",
             n_check, n_check_hit, n_add, n_add_refused, n_clear);
    $display("%0d removes (%0d found), table filled %0d times, %0d results compared",
             n_remove, n_remove_hit, n_full, results_seen);
    if (mismatches == 0) begin
      $display("can_acceptance_filter_table_top verification clean");
    end else begin
      $display("can_acceptance_filter_table_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/caf_pkg.sv
rtl/caf_table.sv
rtl/caf_cmp.sv
rtl/can_acceptance_filter_table_top.sv
tb/sv/testbench.sv
